>>> sv/lpc_residual_ulaw_encoder_macros.svh
// ----------------------------------------------------------------------------
// LPC residual mu-law encoder assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef LPC_RESIDUAL_ULAW_ENCODER_MACROS_SVH
`define LPC_RESIDUAL_ULAW_ENCODER_MACROS_SVH

// same-cycle implication
`define LRUE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrue assertion failed");

// next-cycle implication
`define LRUE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrue assertion failed");

`endif

>>> sv/lrue_pkg.sv
// ----------------------------------------------------------------------------
// lrue_pkg
// Types, constants and the mu-law encoder shared by the LPC residual encoder.
// ----------------------------------------------------------------------------
package lrue_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int COEF_W    = 24;
    localparam int NCOEF_W   = COEF_W + 1;
    localparam int PROD_W    = NCOEF_W + SAMPLE_W;
    localparam int IDX_W     = 4;
    localparam int NUM_SLOTS = 16;
    localparam int FRAC_BITS = 18;
    localparam int MULAW_W   = 8;

    localparam logic [15:0] MU_BIAS = 16'h0084;
    localparam logic [15:0] MU_CLIP = 16'd32635;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_FILTER = 1'b1
    } opcode_t;

    typedef struct packed {
        opcode_t                     opcode;
        logic [IDX_W-1:0]            coef_index;
        logic signed [COEF_W-1:0]    coef_value;
        logic signed [SAMPLE_W-1:0]  sample;
    } cmd_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0]  residual;
        logic [MULAW_W-1:0]          residual_mulaw;
        logic                        saturated;
    } result_item_t;

    typedef struct packed {
        logic              shift;
        logic              load;
        logic [IDX_W-1:0]  index;
    } cell_ctl_t;

    function automatic logic [MULAW_W-1:0] mulaw_encode(input logic signed [SAMPLE_W-1:0] r);
        logic        sign;
        logic [15:0] mag;
        logic [15:0] biased;
        logic [7:0]  top;
        logic [2:0]  ex;
        logic [3:0]  mant;
        sign = r[SAMPLE_W-1];
        mag  = sign ? 16'(-r) : 16'(r);
        if (mag > MU_CLIP)
        begin
            mag = MU_CLIP;
        end
        biased = mag + MU_BIAS;
        top    = biased[14:7];
        ex     = '0;
        for (int i = 1; i < 8; i++)
        begin
            if (top[i])
            begin
                ex = 3'(i);
            end
        end
        mant = 4'(biased >> (4'(ex) + 4'd3));
        return ~{sign, ex, mant};
    endfunction

endpackage

>>> sv/lrue_stream_if.sv
// ----------------------------------------------------------------------------
// lrue_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface lrue_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/lrue_tap_cell.sv
// ----------------------------------------------------------------------------
// lrue_tap_cell
// One filter tap: a delay-line stage, its negated coefficient and a
// registered product handed on to the adder tree.
// ----------------------------------------------------------------------------
module lrue_tap_cell
    import lrue_pkg::*;
#(
    parameter int TAP = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cell_ctl_t                   ctl,
    input  logic signed [COEF_W-1:0]    coef,
    input  logic signed [SAMPLE_W-1:0]  sample_prev,
    output logic signed [SAMPLE_W-1:0]  sample_held,
    output logic signed [PROD_W-1:0]    prod
);

    logic signed [SAMPLE_W-1:0] past_reg,  past_next;
    logic signed [NCOEF_W-1:0]  ncoef_reg, ncoef_next;
    logic signed [PROD_W-1:0]   prod_reg;

    always_comb
    begin
        past_next  = ctl.shift ? sample_prev : past_reg;
        ncoef_next = ncoef_reg;
        if (ctl.load && (ctl.index == IDX_W'(TAP)))
        begin
            ncoef_next = -NCOEF_W'(coef);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            past_reg  <= '0;
            ncoef_reg <= '0;
        end
        else
        begin
            past_reg  <= past_next;
            ncoef_reg <= ncoef_next;
        end
    end

    // product of the pre-shift history, tagged valid upstream
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(ncoef_reg) * PROD_W'(past_reg);
    end

    assign sample_held = past_reg;
    assign prod        = prod_reg;

endmodule

>>> sv/lrue_add_tree.sv
// ----------------------------------------------------------------------------
// lrue_add_tree
// Pipelined binary adder tree, one register level per tree level.
// ----------------------------------------------------------------------------
module lrue_add_tree
    import lrue_pkg::*;
#(
    parameter int N_LEAF = 16,
    parameter int W      = 46
) (
    input  logic                clk,
    input  logic signed [W-1:0] leaf [N_LEAF],
    output logic signed [W-1:0] root
);

    localparam int LVL = (N_LEAF > 1) ? $clog2(N_LEAF) : 1;
    localparam int P   = 1 << LVL;

    logic signed [W-1:0] leaf_pad [P];
    logic signed [W-1:0] sum_reg  [1:P-1];

    for (genvar j = 0; j < P; j++)
    begin : g_pad
        if (j < N_LEAF)
        begin : g_real
            assign leaf_pad[j] = leaf[j];
        end
        else
        begin : g_zero
            assign leaf_pad[j] = '0;
        end
    end

    for (genvar i = 1; i < P; i++)
    begin : g_node
        if (2 * i >= P)
        begin : g_bottom
            always_ff @(posedge clk)
            begin
                sum_reg[i] <= leaf_pad[2*i-P] + leaf_pad[2*i+1-P];
            end
        end
        else
        begin : g_inner
            always_ff @(posedge clk)
            begin
                sum_reg[i] <= sum_reg[2*i] + sum_reg[2*i+1];
            end
        end
    end

    assign root = sum_reg[1];

endmodule

>>> sv/lrue_out_fifo.sv
// ----------------------------------------------------------------------------
// lrue_out_fifo
// Small result queue that decouples the filter pipeline from the sink.
// ----------------------------------------------------------------------------
module lrue_out_fifo
    import lrue_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  result_item_t           wr_data,
    lrue_stream_if.source          result
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;

    result_item_t       mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               pop;

    assign pop = result.valid && result.ready;

    always_comb
    begin
        wr_ptr_next = wr_en ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop   ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(wr_en) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign result.valid = (count_reg != '0);
    assign result.data  = mem[rd_ptr_reg];

endmodule

>>> sv/lpc_residual_ulaw_encoder.sv
// ----------------------------------------------------------------------------
// lpc_residual_ulaw_encoder
// LPC inverse filter over a chain of tap cells, truncation, saturation and
// G.711 mu-law encoding of the prediction residual.
// ----------------------------------------------------------------------------
//  channel | dir | payload        | transaction
//  --------+-----+----------------+-------------------------------------------
//  cmd     | in  | cmd_item_t     | coefficient load or one sample to filter
//  result  | out | result_item_t  | one residual per filtered sample
//
//  One command per cycle while cmd.ready is high. A sample goes through the
//  tap product registers, adder tree levels, q_reg and res_reg to the queue.
//  cmd.ready drops only when the output queue plus samples in flight fill it.
//  Reset clears the delay line and all coefficients at once.
// ----------------------------------------------------------------------------
module lpc_residual_ulaw_encoder
    import lrue_pkg::*;
#(
    parameter int ORDER = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    lrue_stream_if.sink   cmd,
    lrue_stream_if.source result
);

    localparam int NCELL  = (ORDER - 1 < NUM_SLOTS - 1) ? ORDER - 1 : NUM_SLOTS - 1;
    localparam int NLEAF  = NCELL + 1;
    localparam int LVL    = $clog2(NLEAF);
    localparam int ACC_W  = PROD_W + $clog2(NLEAF);
    localparam int Q_W    = ACC_W - FRAC_BITS;
    localparam int PIPE   = LVL + 3;
    localparam int QDEPTH = 1 << $clog2(PIPE + 2);
    localparam int CNT_W  = $clog2(QDEPTH) + 1;

    logic                        fire, fire_filter, pop;
    cell_ctl_t                   ctl;
    logic signed [SAMPLE_W-1:0]  past [0:NCELL];
    logic signed [PROD_W-1:0]    prod [1:NCELL];
    logic signed [ACC_W-1:0]     leaf [NLEAF];
    logic signed [ACC_W-1:0]     acc_root;

    logic signed [SAMPLE_W-1:0]  sample_reg;
    logic [PIPE-1:0]             vld_reg, vld_next;
    logic [CNT_W-1:0]            used_reg, used_next;

    logic signed [Q_W-1:0]       q_reg, q_next;
    logic signed [SAMPLE_W-1:0]  res_reg, res_next;
    logic                        sat_reg, sat_next;
    result_item_t                wr_item;

    assign fire        = cmd.valid && cmd.ready;
    assign fire_filter = fire && (cmd.data.opcode == OP_FILTER);
    assign pop         = result.valid && result.ready;
    assign cmd.ready   = (used_reg < CNT_W'(QDEPTH));

    assign ctl.shift = fire_filter;
    assign ctl.load  = fire && (cmd.data.opcode == OP_LOAD);
    assign ctl.index = cmd.data.coef_index;

    assign past[0] = cmd.data.sample;

    for (genvar k = 1; k <= NCELL; k++)
    begin : g_cell
        lrue_tap_cell #(
            .TAP (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .coef        (cmd.data.coef_value),
            .sample_prev (past[k-1]),
            .sample_held (past[k]),
            .prod        (prod[k])
        );
        assign leaf[k] = ACC_W'(prod[k]);
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= cmd.data.sample;
    end

    assign leaf[0] = ACC_W'(sample_reg) <<< FRAC_BITS;

    lrue_add_tree #(
        .N_LEAF (NLEAF),
        .W      (ACC_W)
    ) u_tree (
        .clk  (clk),
        .leaf (leaf),
        .root (acc_root)
    );

    // truncate toward zero, then saturate
    always_comb
    begin
        q_next = Q_W'(acc_root >>> FRAC_BITS)
               + Q_W'(acc_root[ACC_W-1] & (|acc_root[FRAC_BITS-1:0]));
        res_next = q_reg[SAMPLE_W-1:0];
        sat_next = 1'b0;
        if (!((&q_reg[Q_W-1:SAMPLE_W-1]) || !(|q_reg[Q_W-1:SAMPLE_W-1])))
        begin
            sat_next = 1'b1;
            res_next = q_reg[Q_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                    : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        res_reg <= res_next;
        sat_reg <= sat_next;
    end

    always_comb
    begin
        vld_next  = {vld_reg[PIPE-2:0], fire_filter};
        used_next = used_reg + CNT_W'(fire_filter) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            used_reg <= '0;
        end
        else
        begin
            vld_reg  <= vld_next;
            used_reg <= used_next;
        end
    end

    always_comb
    begin
        wr_item.residual       = res_reg;
        wr_item.residual_mulaw = mulaw_encode(res_reg);
        wr_item.saturated      = sat_reg;
    end

    lrue_out_fifo #(
        .DEPTH (QDEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (vld_reg[PIPE-1]),
        .wr_data (wr_item),
        .result  (result)
    );

endmodule

>>> sv/lrue_checker.sv
// ----------------------------------------------------------------------------
// lrue_checker
// Port-level checks on the result channel of the LPC residual encoder.
// ----------------------------------------------------------------------------
`include "lpc_residual_ulaw_encoder_macros.svh"

module lrue_checker
    import lrue_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          result_valid,
    input  logic          result_ready,
    input  result_item_t  result_data
);

    `LRUE_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(result_data))
    `LRUE_ASSERT_NOW(a_sat_clip, result_valid && result_data.saturated, (result_data.residual == 16'h7FFF) || (result_data.residual == 16'h8000))
    `LRUE_ASSERT_NOW(a_sign_code, result_valid, result_data.residual[SAMPLE_W-1] != result_data.residual_mulaw[MULAW_W-1])
    `LRUE_ASSERT_NOW(a_zero_code, result_valid && (result_data.residual == '0), result_data.residual_mulaw == 8'hFF)

endmodule

bind lpc_residual_ulaw_encoder lrue_checker u_lrue_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
